// ----- rtl/core/stable_kway_merge_assert.svh -----
// ---------------------------------------------------------------------------
// stable_kway_merge_assert.svh
// Assertion macros for the k-way merge block. Defining NO_ASSERTIONS turns
// every macro into an empty body.
// ---------------------------------------------------------------------------
`ifndef STABLE_KWAY_MERGE_ASSERT_SVH
`define STABLE_KWAY_MERGE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Condition holds at every edge out of reset.
`define SKM_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define SKM_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the next cycle.
`define SKM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define SKM_ASSERT_ALWAYS(label, cond, msg)
`define SKM_ASSERT_IMPLY(label, ante, cons, msg)
`define SKM_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// ----- rtl/core/skm_pkg.sv -----
// ---------------------------------------------------------------------------
// skm_pkg
// Shared constants, transaction types and control structs of the merge block.
// ---------------------------------------------------------------------------
package skm_pkg;

  localparam int MAX_STREAMS  = 16;
  localparam int KEY_BITS     = 32;
  localparam int PAYLOAD_BITS = 32;

  localparam int STREAM_W     = 4;
  localparam int STREAM_REACH = 1 << STREAM_W;
  localparam int SC_W         = 5;
  localparam int CNT_W        = $clog2(MAX_STREAMS + 1);
  localparam int FILL_CAP     = (MAX_STREAMS < STREAM_REACH) ? MAX_STREAMS : STREAM_REACH;
  localparam int ADDR_W       = 3;
  localparam int DATA_W       = 32;

  // register index (paddr[2])
  localparam logic REG_DESCENDING   = 1'b0;
  localparam logic REG_STREAM_COUNT = 1'b1;

  typedef enum logic [1:0] {
    ST_EMIT  = 2'd0,
    ST_DONE  = 2'd1,
    ST_WRONG = 2'd2
  } status_t;

  typedef struct packed {
    logic [STREAM_W-1:0] stream;
    logic                exhausted;
    logic signed [31:0]  sort_key;
    logic [31:0]         payload;
  } elem_t;

  typedef struct packed {
    status_t             status;
    logic signed [31:0]  out_key;
    logic [31:0]         out_payload;
    logic [STREAM_W-1:0] source_stream;
  } res_t;

  typedef enum logic {
    S_IDLE,
    S_RESULT
  } state_t;

  typedef enum logic {
    RK_HEAD,
    RK_WRONG
  } res_kind_t;

  // controller -> datapath
  typedef struct packed {
    logic                update;
    logic                ins;
    logic                drp;
    logic                load;
    res_kind_t           kind;
    logic [STREAM_W-1:0] wrong_src;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [CNT_W-1:0]    live_count;
    logic [STREAM_W-1:0] head_stream;
  } dp_stat_t;

endpackage

// ----- rtl/core/skm_ctrl.sv -----
// ---------------------------------------------------------------------------
// skm_ctrl
// Merge sequencer: fill/emit phase, expected stream check, result handoff.
// ---------------------------------------------------------------------------
module skm_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       elem_valid,
  output logic                       elem_ready,
  input  skm_pkg::elem_t             elem,
  output logic                       res_valid,
  input  logic                       res_ready,
  input  logic [skm_pkg::SC_W-1:0]   stream_count,
  input  skm_pkg::dp_stat_t          stat,
  output skm_pkg::dp_cmd_t           cmd
);

  skm_pkg::state_t                    state, state_next;
  skm_pkg::res_kind_t                 kind, kind_next;
  logic                               emitting, emitting_next;
  logic [skm_pkg::SC_W-1:0]           fill_count, fill_count_next;
  logic [skm_pkg::STREAM_W-1:0]       expected, expected_next;
  logic                               res_valid_next;
  logic [skm_pkg::SC_W-1:0]           lim;
  logic [skm_pkg::SC_W-1:0]           fill_inc;

  assign lim = (stream_count > skm_pkg::SC_W'(skm_pkg::FILL_CAP)) ?
               skm_pkg::SC_W'(skm_pkg::FILL_CAP) : stream_count;
  assign fill_inc = fill_count + skm_pkg::SC_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= skm_pkg::S_IDLE;
      kind       <= skm_pkg::RK_HEAD;
      emitting   <= 1'b0;
      fill_count <= '0;
      expected   <= '0;
      res_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      kind       <= kind_next;
      emitting   <= emitting_next;
      fill_count <= fill_count_next;
      expected   <= expected_next;
      res_valid  <= res_valid_next;
    end
  end

  always_comb begin
    state_next      = state;
    kind_next       = kind;
    emitting_next   = emitting;
    fill_count_next = fill_count;
    expected_next   = expected;
    res_valid_next  = res_ready ? 1'b0 : res_valid;
    elem_ready      = (state == skm_pkg::S_IDLE);
    cmd             = '0;
    cmd.kind        = kind;
    cmd.wrong_src   = expected;

    unique case (state)
      skm_pkg::S_IDLE: begin
        if (elem_valid) begin
          if (!emitting) begin
            priority if (fill_count >= lim) begin
              // fill already over (count lowered or zero): drop, then emit/finish
              kind_next  = skm_pkg::RK_HEAD;
              state_next = skm_pkg::S_RESULT;
            end else if (skm_pkg::SC_W'(elem.stream) != fill_count) begin
              expected_next = fill_count[skm_pkg::STREAM_W-1:0];
              kind_next     = skm_pkg::RK_WRONG;
              state_next    = skm_pkg::S_RESULT;
            end else begin
              cmd.update      = 1'b1;
              cmd.ins         = !elem.exhausted;
              fill_count_next = fill_inc;
              expected_next   = fill_inc[skm_pkg::STREAM_W-1:0];
              if (fill_inc >= lim) begin
                kind_next  = skm_pkg::RK_HEAD;
                state_next = skm_pkg::S_RESULT;
              end
            end
          end else begin
            if (elem.stream != expected) begin
              kind_next  = skm_pkg::RK_WRONG;
              state_next = skm_pkg::S_RESULT;
            end else begin
              cmd.update = 1'b1;
              cmd.drp    = 1'b1;
              cmd.ins    = !elem.exhausted;
              kind_next  = skm_pkg::RK_HEAD;
              state_next = skm_pkg::S_RESULT;
            end
          end
        end
      end
      skm_pkg::S_RESULT: begin
        if (!res_valid || res_ready) begin
          cmd.load       = 1'b1;
          res_valid_next = 1'b1;
          state_next     = skm_pkg::S_IDLE;
          if (kind == skm_pkg::RK_HEAD) begin
            if (stat.live_count == '0) begin
              emitting_next   = 1'b0;
              fill_count_next = '0;
              expected_next   = '0;
            end else begin
              emitting_next = 1'b1;
              expected_next = stat.head_stream;
            end
          end
        end
      end
      default: begin
        state_next = skm_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/core/skm_datapath.sv -----
// ---------------------------------------------------------------------------
// skm_datapath
// Sorted head register array with combined drop/insert update, and result register.
// ---------------------------------------------------------------------------
module skm_datapath (
  input  logic                clk,
  input  logic                rst,
  input  skm_pkg::dp_cmd_t    cmd,
  input  logic                descending,
  input  skm_pkg::elem_t      elem,
  output skm_pkg::dp_stat_t   stat,
  output skm_pkg::res_t       res
);

  localparam int N = skm_pkg::MAX_STREAMS;

  logic signed [skm_pkg::KEY_BITS-1:0] head_key     [N];
  logic [skm_pkg::PAYLOAD_BITS-1:0]    head_payload [N];
  logic [skm_pkg::STREAM_W-1:0]        head_stream  [N];

  logic signed [skm_pkg::KEY_BITS-1:0] src_key      [N];
  logic [skm_pkg::PAYLOAD_BITS-1:0]    src_payload  [N];
  logic [skm_pkg::STREAM_W-1:0]        src_stream   [N];

  logic signed [skm_pkg::KEY_BITS-1:0] nxt_key      [N];
  logic [skm_pkg::PAYLOAD_BITS-1:0]    nxt_payload  [N];
  logic [skm_pkg::STREAM_W-1:0]        nxt_stream   [N];

  logic [N-1:0]                        later;
  logic [skm_pkg::CNT_W-1:0]           live_count;
  logic [skm_pkg::CNT_W-1:0]           src_live;
  logic                                drop_eff;
  logic                                ins_eff;
  logic signed [skm_pkg::KEY_BITS-1:0] new_key;
  logic [skm_pkg::PAYLOAD_BITS-1:0]    new_payload;
  skm_pkg::res_t                       res_next;

  // a strictly ahead of b in merge order; ties go to the lower stream
  function automatic logic goes_before(
    input logic signed [skm_pkg::KEY_BITS-1:0] ka,
    input logic [skm_pkg::STREAM_W-1:0]        sa,
    input logic signed [skm_pkg::KEY_BITS-1:0] kb,
    input logic [skm_pkg::STREAM_W-1:0]        sb,
    input logic                                desc
  );
    if (ka != kb) begin
      return desc ? (ka > kb) : (ka < kb);
    end
    return sa < sb;
  endfunction

  assign new_key     = skm_pkg::KEY_BITS'(elem.sort_key);
  assign new_payload = skm_pkg::PAYLOAD_BITS'(elem.payload);

  assign drop_eff = cmd.drp && (live_count != '0);
  assign src_live = drop_eff ? live_count - skm_pkg::CNT_W'(1) : live_count;
  assign ins_eff  = cmd.ins && (src_live < skm_pkg::CNT_W'(N));

  for (genvar i = 0; i < N; i++) begin : g_ent
    // view after the optional drop of the best head
    if (i < N - 1) begin : g_shift
      assign src_key[i]     = drop_eff ? head_key[i+1]     : head_key[i];
      assign src_payload[i] = drop_eff ? head_payload[i+1] : head_payload[i];
      assign src_stream[i]  = drop_eff ? head_stream[i+1]  : head_stream[i];
    end else begin : g_last
      assign src_key[i]     = head_key[i];
      assign src_payload[i] = head_payload[i];
      assign src_stream[i]  = head_stream[i];
    end

    // new entry sorts ahead of this slot (empty slots count as behind)
    assign later[i] = (skm_pkg::CNT_W'(i) < src_live) ?
                      goes_before(new_key, elem.stream, src_key[i], src_stream[i],
                                  descending) : 1'b1;

    if (i == 0) begin : g_first
      always_comb begin
        if (ins_eff && later[i]) begin
          nxt_key[i]     = new_key;
          nxt_payload[i] = new_payload;
          nxt_stream[i]  = elem.stream;
        end else begin
          nxt_key[i]     = src_key[i];
          nxt_payload[i] = src_payload[i];
          nxt_stream[i]  = src_stream[i];
        end
      end
    end else begin : g_rest
      always_comb begin
        if (!ins_eff || !later[i]) begin
          nxt_key[i]     = src_key[i];
          nxt_payload[i] = src_payload[i];
          nxt_stream[i]  = src_stream[i];
        end else if (!later[i-1]) begin
          nxt_key[i]     = new_key;
          nxt_payload[i] = new_payload;
          nxt_stream[i]  = elem.stream;
        end else begin
          nxt_key[i]     = src_key[i-1];
          nxt_payload[i] = src_payload[i-1];
          nxt_stream[i]  = src_stream[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      for (int i = 0; i < N; i++) begin
        head_key[i]     <= nxt_key[i];
        head_payload[i] <= nxt_payload[i];
        head_stream[i]  <= nxt_stream[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      live_count <= '0;
    end else if (cmd.update) begin
      live_count <= src_live + skm_pkg::CNT_W'(ins_eff);
    end
  end

  always_comb begin
    res_next = '0;
    unique case (cmd.kind)
      skm_pkg::RK_WRONG: begin
        res_next.status        = skm_pkg::ST_WRONG;
        res_next.source_stream = cmd.wrong_src;
      end
      skm_pkg::RK_HEAD: begin
        if (live_count == '0) begin
          res_next.status = skm_pkg::ST_DONE;
        end else begin
          res_next.status        = skm_pkg::ST_EMIT;
          res_next.out_key       = 32'(head_key[0]);
          res_next.out_payload   = 32'(head_payload[0]);
          res_next.source_stream = head_stream[0];
        end
      end
      default: begin
        res_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res <= res_next;
    end
  end

  assign stat.live_count  = live_count;
  assign stat.head_stream = head_stream[0];

endmodule

// ----- rtl/core/stable_kway_merge.sv -----
// ---------------------------------------------------------------------------
// stable_kway_merge
// Stable k-way merge of sorted streams with an APB-style register port.
// ---------------------------------------------------------------------------
// Usage: after reset (or a finished result) the block is in its fill phase
// and takes one transaction from stream 0, 1, 2, ... up to stream_count-1,
// each carrying that stream's first element or its exhausted mark. After the
// last fill transaction it returns the best head (status 0) and names the
// source stream; the next transaction must come from that stream, either its
// next element or its exhausted mark, and the next best head follows. When no
// head is left it returns status 1 and goes back to the fill phase. A
// transaction from any other stream is dropped with status 2 and the expected
// stream in source_stream. Order is ascending, or descending with the
// descending register set; equal keys leave in stream order.
// Timing: the sorted head registers are updated when a transaction is taken,
// by a parallel compare-and-shift over all heads. A transaction that produces
// a result then enters the result state, which loads the result register from
// the best head; no new transaction is taken before that. Fill transactions
// that produce nothing keep the block idle. A result that finds the
// result register still occupied waits there until the downstream side takes
// the earlier one. Registers: 0x0 descending (bit 0), 0x4 stream_count
// (bits 4:0, reset 2, values above 16 behave as 16). Write them only while
// the block is idle.
// ---------------------------------------------------------------------------
`include "stable_kway_merge_assert.svh"

module stable_kway_merge (
  input  logic                          clk,
  input  logic                          rst,
  // element transactions
  input  logic                          elem_valid,
  output logic                          elem_ready,
  input  skm_pkg::elem_t                elem,
  // result transactions
  output logic                          res_valid,
  input  logic                          res_ready,
  output skm_pkg::res_t                 res,
  // register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [skm_pkg::ADDR_W-1:0]    paddr,
  input  logic [skm_pkg::DATA_W-1:0]    pwdata,
  output logic [skm_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);

  logic                        descending;
  logic [skm_pkg::SC_W-1:0]    stream_count;
  logic                        reg_idx;
  logic                        reg_wr;
  skm_pkg::dp_cmd_t            cmd;
  skm_pkg::dp_stat_t           stat;

  // -------------------------------------------------------------------------
  // Register port: zero wait states, index from address bit 2.
  // -------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign reg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      descending   <= 1'b0;
      stream_count <= skm_pkg::SC_W'(2);
    end else if (reg_wr) begin
      unique case (reg_idx)
        skm_pkg::REG_DESCENDING:   descending   <= pwdata[0];
        skm_pkg::REG_STREAM_COUNT: stream_count <= pwdata[skm_pkg::SC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      skm_pkg::REG_DESCENDING:   prdata = skm_pkg::DATA_W'(descending);
      skm_pkg::REG_STREAM_COUNT: prdata = skm_pkg::DATA_W'(stream_count);
      default:                   prdata = '0;
    endcase
  end

  // -------------------------------------------------------------------------
  // Sequencer: phase, expected stream, result handoff.
  // -------------------------------------------------------------------------
  skm_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .elem_valid   (elem_valid),
    .elem_ready   (elem_ready),
    .elem         (elem),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .stream_count (stream_count),
    .stat         (stat),
    .cmd          (cmd)
  );

  // -------------------------------------------------------------------------
  // Head array and result register.
  // -------------------------------------------------------------------------
  skm_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .descending (descending),
    .elem       (elem),
    .stat       (stat),
    .res        (res)
  );

  // -------------------------------------------------------------------------
  // Checks
  // -------------------------------------------------------------------------
  // head array only changes on a taken transaction
  `SKM_ASSERT_IMPLY(a_update_on_accept, cmd.update, elem_valid && elem_ready, "head update without transaction")
  // result load cycle never overlaps a new transaction
  `SKM_ASSERT_IMPLY(a_no_take_on_load, cmd.load, !elem_ready, "transaction taken during result load")
  // a loaded result is presented next cycle
  `SKM_ASSERT_NEXT(a_load_presents, cmd.load, res_valid, "loaded result not presented")
  // live heads never exceed the array
  `SKM_ASSERT_ALWAYS(a_live_bound, stat.live_count <= skm_pkg::CNT_W'(skm_pkg::MAX_STREAMS), "live count overflow")

endmodule

// ----- tb/stable_kway_merge_test.sv -----
// ============================================================================
// stable_kway_merge_test
// Self-checking bench for the k-way merge. It drives well-formed merges of
// sorted streams with random content, with some wrong-stream transactions and
// unsorted streams mixed in. A scoreboard keeps its own copy of the sorted
// heads, predicts each result, and checks the results field by field.
// ============================================================================
module stable_kway_merge_test;
  timeunit 1ns;
  timeprecision 1ps;

  import skm_pkg::*;

  localparam int KEY_HI = 2147483647;
  localparam int KEY_LO = -2147483647 - 1;

  // --------------------------------------------------------------------------
  // Scoreboard: keeps the head table and the register copies, and holds the
  // results still owed by the block, oldest first.
  // --------------------------------------------------------------------------
  class merge_scoreboard;
    bit                 desc_order;
    logic [4:0]         stream_cnt;
    logic signed [31:0] hd_key[MAX_STREAMS];
    logic [31:0]        hd_pay[MAX_STREAMS];
    logic [3:0]         hd_src[MAX_STREAMS];
    int                 live;
    int                 filled;
    bit                 draining;     // emission phase
    logic [3:0]         want_src;
    bit                 merge_done;   // a finished result was predicted
    res_t               owed[$];
    int                 errors;

    function new();
      desc_order = 1'b0;
      stream_cnt = 5'd2;
      live       = 0;
      filled     = 0;
      draining   = 1'b0;
      want_src   = '0;
      merge_done = 1'b0;
      errors     = 0;
    endfunction

    function void write_reg(logic idx, logic [31:0] v);
      if (idx == REG_DESCENDING) desc_order = v[0];
      else stream_cnt = v[4:0];
    endfunction

    function logic [3:0] next_stream();
      return draining ? want_src : 4'(filled);
    endfunction

    // strict merge order; equal keys go to the lower stream
    function bit ranks_before(logic signed [31:0] ka, logic [3:0] sa,
                              logic signed [31:0] kb, logic [3:0] sb);
      if (ka != kb) return desc_order ? (ka > kb) : (ka < kb);
      return sa < sb;
    endfunction

    function void insert_head(logic signed [31:0] k, logic [31:0] p, logic [3:0] s);
      int pos;
      if (live >= MAX_STREAMS) return;
      pos = 0;
      while (pos < live && !ranks_before(k, s, hd_key[pos], hd_src[pos])) pos++;
      for (int i = live; i > pos; i--) begin
        hd_key[i] = hd_key[i-1];
        hd_pay[i] = hd_pay[i-1];
        hd_src[i] = hd_src[i-1];
      end
      hd_key[pos] = k;
      hd_pay[pos] = p;
      hd_src[pos] = s;
      live++;
    endfunction

    function void drop_best();
      if (live == 0) return;
      for (int i = 1; i < live; i++) begin
        hd_key[i-1] = hd_key[i];
        hd_pay[i-1] = hd_pay[i];
        hd_src[i-1] = hd_src[i];
      end
      live--;
    endfunction

    function void queue_result(status_t st, logic signed [31:0] k, logic [31:0] p,
                               logic [3:0] s);
      res_t r;
      r.status        = st;
      r.out_key       = k;
      r.out_payload   = p;
      r.source_stream = s;
      owed.push_back(r);
    endfunction

    function void emit_or_finish();
      if (live == 0) begin
        draining   = 1'b0;
        filled     = 0;
        want_src   = '0;
        merge_done = 1'b1;
        queue_result(ST_DONE, '0, '0, '0);
      end else begin
        draining = 1'b1;
        want_src = hd_src[0];
        queue_result(ST_EMIT, hd_key[0], hd_pay[0], hd_src[0]);
      end
    endfunction

    // Returns 1 when the transaction changed the merge (not dropped).
    function bit note_elem(elem_t e);
      int lim;
      if (!draining) begin
        lim = (stream_cnt > FILL_CAP) ? FILL_CAP : int'(stream_cnt);
        if (filled >= lim) begin
          emit_or_finish();
          return 1'b0;
        end
        want_src = 4'(filled);
        if (e.stream != want_src) begin
          queue_result(ST_WRONG, '0, '0, want_src);
          return 1'b0;
        end
        if (!e.exhausted) insert_head(e.sort_key, e.payload, e.stream);
        filled++;
        if (filled >= lim) emit_or_finish();
        else want_src = 4'(filled);
        return 1'b1;
      end
      if (e.stream != want_src) begin
        queue_result(ST_WRONG, '0, '0, want_src);
        return 1'b0;
      end
      drop_best();
      if (!e.exhausted) insert_head(e.sort_key, e.payload, e.stream);
      emit_or_finish();
      return 1'b1;
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (owed.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("result with nothing outstanding: status %0d key %0d pay %h src %0d",
                   got.status, got.out_key, got.out_payload, got.source_stream);
        return;
      end
      want = owed.pop_front();
      if (got.status !== want.status || got.out_key !== want.out_key ||
          got.out_payload !== want.out_payload ||
          got.source_stream !== want.source_stream) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: status %0d/%0d key %0d/%0d pay %h/%h src %0d/%0d (exp/got)",
                   want.status, got.status, want.out_key, got.out_key,
                   want.out_payload, got.out_payload,
                   want.source_stream, got.source_stream);
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT hookup
  // --------------------------------------------------------------------------
  logic                clk;
  logic                rst;
  logic                elem_valid;
  logic                elem_ready;
  elem_t               elem;
  logic                res_valid;
  logic                res_ready;
  res_t                res;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  stable_kway_merge dut (
    .clk        (clk),
    .rst        (rst),
    .elem_valid (elem_valid),
    .elem_ready (elem_ready),
    .elem       (elem),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  merge_scoreboard sb = new();

  int key_q[MAX_STREAMS][$];   // keys still to send, per stream
  int items_done = 0;          // transactions that took effect
  bit steady = 1'b0;           // no idling on either side while set

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Result side: random backpressure, ~27% of cycles stalled.
  initial begin
    res_ready = 1'b0;
    forever begin
      @(negedge clk);
      res_ready = steady || ($urandom_range(0, 99) >= 27);
    end
  end

  // Every accepted result transaction is checked against the oldest owed one.
  always @(posedge clk) begin
    if (!rst && res_valid === 1'b1 && res_ready) sb.check_result(res);
  end

  // --------------------------------------------------------------------------
  // Drivers. All tasks start and end at a falling edge.
  // --------------------------------------------------------------------------
  task automatic cfg_write(input logic idx, input logic [31:0] v);
    elem_valid = 1'b0;
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = v;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    sb.write_reg(idx, v);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // One element transaction, with random idle cycles in front.
  task automatic send_elem(input elem_t e);
    while (!steady && $urandom_range(0, 99) < 27) begin
      elem_valid = 1'b0;
      @(negedge clk);
    end
    elem       = e;
    elem_valid = 1'b1;
    do @(posedge clk); while (elem_ready !== 1'b1);
    if (sb.note_elem(e)) items_done++;
    @(negedge clk);
  endtask

  task automatic hold_until_drained();
    elem_valid = 1'b0;
    while (sb.owed.size() != 0) @(negedge clk);
  endtask

  // Registers only change with the block idle; fill transactions give no
  // result, so wait as well for the last one to settle.
  task automatic begin_merge(input int cnt, input bit desc);
    hold_until_drained();
    repeat (8) @(negedge clk);
    cfg_write(REG_DESCENDING, 32'(desc));
    cfg_write(REG_STREAM_COUNT, 32'(cnt));
  endtask

  function automatic elem_t make_elem(logic [3:0] s, logic gone,
                                      logic signed [31:0] k, logic [31:0] p);
    elem_t e;
    e.stream    = s;
    e.exhausted = gone;
    e.sort_key  = k;
    e.payload   = p;
    return e;
  endfunction

  function automatic logic [31:0] pick_payload();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic int pick_key();
    case ($urandom_range(0, 9))
      0:       return KEY_LO;
      1:       return KEY_HI;
      default: return $urandom;
    endcase
  endfunction

  task automatic clear_streams();
    foreach (key_q[s]) key_q[s].delete();
  endtask

  // Feed the stream the block asks for next until the merge finishes.
  // noise_pct of the transactions come from a wrong stream instead.
  task automatic drive_merge(input int noise_pct);
    logic [3:0] src;
    elem_t      e;
    sb.merge_done = 1'b0;
    while (!sb.merge_done) begin
      if ($urandom_range(0, 99) < 2) hold_until_drained();
      src = sb.next_stream();
      if ($urandom_range(0, 99) < noise_pct)
        e = make_elem(src ^ 4'($urandom_range(1, 15)), 1'($urandom_range(0, 1)),
                      $urandom, pick_payload());
      else if (key_q[src].size() == 0)
        e = make_elem(src, 1'b1, $urandom, $urandom);
      else
        e = make_elem(src, 1'b0, key_q[src].pop_front(), pick_payload());
      send_elem(e);
    end
  endtask

  // Random merge: mostly a few short streams, sometimes all sixteen or a
  // saturating count, sometimes tie-heavy, unsorted or noisy.
  task automatic random_merge();
    int cnt;
    int sel;
    int maxlen;
    int mode;
    int len;
    bit desc;
    sel  = $urandom_range(0, 99);
    desc = 1'($urandom_range(0, 1));
    mode = $urandom_range(0, 9);   // 0-1 narrow keys, 2 unsorted, else wide
    if (sel < 4) cnt = 0;
    else if (sel < 12) cnt = 16;
    else if (sel < 18) cnt = $urandom_range(17, 31);
    else cnt = $urandom_range(1, 6);
    maxlen = (cnt > 6) ? 2 : 6;
    begin_merge(cnt, desc);
    clear_streams();
    foreach (key_q[s]) begin
      len = $urandom_range(0, maxlen);
      repeat (len) key_q[s].push_back(mode < 2 ? $urandom_range(0, 6) - 3 : pick_key());
      if (mode != 2) begin
        if (desc) key_q[s].rsort();
        else key_q[s].sort();
      end
    end
    drive_merge(($urandom_range(0, 9) == 0) ? 25 : 4);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst        = 1'b1;
    elem_valid = 1'b0;
    elem       = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // ascending, tie on key 5 between streams 0 and 1, key extremes,
    // stream 2 exhausted at fill
    begin_merge(3, 1'b0);
    clear_streams();
    key_q[0] = '{KEY_LO, 5};
    key_q[1] = '{5, KEY_HI};
    drive_merge(0);

    // descending, equal top keys; a wrong stream during fill first
    begin_merge(2, 1'b1);
    clear_streams();
    key_q[0] = '{KEY_HI, -1};
    key_q[1] = '{KEY_HI, KEY_LO};
    send_elem(make_elem(4'hF, 1'b1, -1, '1));
    drive_merge(0);

    // no streams: finished at once; one stream that is empty from the start
    begin_merge(0, 1'b0);
    clear_streams();
    drive_merge(0);
    begin_merge(1, 1'b1);
    drive_merge(0);

    // count lowered below the fill position: the next transaction is dropped
    // and the merge starts from the heads already taken
    begin_merge(4, 1'b0);
    clear_streams();
    key_q[0] = '{3};
    key_q[1] = '{-2, 7};
    key_q[2] = '{-2};
    for (int s = 0; s < 3; s++)
      send_elem(make_elem(4'(s), 1'b0, key_q[s].pop_front(), pick_payload()));
    hold_until_drained();
    repeat (8) @(negedge clk);
    cfg_write(REG_STREAM_COUNT, 32'd2);
    drive_merge(0);

    // random merges, with one long stretch without idling
    while (items_done < 550) begin
      steady = (items_done >= 250 && items_done < 340);
      random_merge();
    end
    steady = 1'b0;

    hold_until_drained();
    repeat (20) @(negedge clk);
    if (sb.errors == 0 && sb.owed.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/skm_pkg.sv
rtl/core/skm_ctrl.sv
rtl/core/skm_datapath.sv
rtl/core/stable_kway_merge.sv
tb/stable_kway_merge_test.sv
